// ----- rtl/core/slbb_pkg.sv -----
package slbb_pkg;

    localparam int TIME_BITS = 32;
    localparam int ADDR_BITS = 3;

    localparam logic [6:0]  LEVEL_MAX    = 7'd100;
    localparam logic [6:0]  RED_ON_LEVEL = 7'd100;
    localparam logic [6:0]  FINE_STEP    = 7'd1;
    localparam logic [6:0]  COARSE_STEP  = 7'd10;
    localparam logic [15:0] DIM_RESET    = 16'd10;
    localparam logic [15:0] BLINK_RESET  = 16'd200;

    localparam logic REG_DIM_INTERVAL   = 1'b0;
    localparam logic REG_BLINK_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SET_MODE   = 2'd1,
        FUNC_MANUAL_SET = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ERROR  = 2'd1,
        MODE_BUSY   = 2'd2,
        MODE_MANUAL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] now_ms;
        logic [1:0]           new_mode;
        logic                 manual_on;
    } item_t;

    typedef struct packed {
        mode_t                mode;
        logic [6:0]           dim_level;
        dir_t                 dim_direction;
        logic [TIME_BITS-1:0] dim_stamp;
        logic                 red_on;
        logic [TIME_BITS-1:0] blink_stamp;
    } state_t;

    typedef struct packed {
        logic [6:0] blue_level;
        logic [6:0] red_level;
        logic [1:0] current_mode;
        logic       accepted;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        mode:          MODE_IDLE,
        dim_level:     7'd0,
        dim_direction: DIR_NONE,
        dim_stamp:     '0,
        red_on:        1'b0,
        blink_stamp:   '0
    };

endpackage

// ----- rtl/core/slbb_step.sv -----
module slbb_step (
    input  slbb_pkg::item_t   item,
    input  slbb_pkg::state_t  state,
    input  logic [15:0]       dim_interval,
    input  logic [15:0]       blink_interval,
    output slbb_pkg::state_t  state_next,
    output slbb_pkg::result_t result
);

    logic [slbb_pkg::TIME_BITS-1:0] dim_diff;
    logic [slbb_pkg::TIME_BITS-1:0] blink_diff;
    logic                           dim_due;
    logic                           blink_due;
    logic [6:0]                     step;
    slbb_pkg::dir_t                 dir_sel;
    logic [7:0]                     up_sum;
    logic [6:0]                     up_level;
    logic [6:0]                     down_level;
    logic [6:0]                     breathe_level;
    logic                           accepted;

    assign dim_diff   = item.now_ms - state.dim_stamp;
    assign blink_diff = item.now_ms - state.blink_stamp;
    assign dim_due    = dim_diff >= slbb_pkg::TIME_BITS'(dim_interval);
    assign blink_due  = blink_diff >= slbb_pkg::TIME_BITS'(blink_interval);

    assign step = (state.mode == slbb_pkg::MODE_MANUAL) ? slbb_pkg::COARSE_STEP
                                                        : slbb_pkg::FINE_STEP;

    always_comb begin
        if (state.dim_level == 7'd0) begin
            dir_sel = slbb_pkg::DIR_UP;
        end else if (state.dim_level >= slbb_pkg::LEVEL_MAX) begin
            dir_sel = slbb_pkg::DIR_DOWN;
        end else begin
            dir_sel = state.dim_direction;
        end
    end

    assign up_sum     = {1'b0, state.dim_level} + {1'b0, step};
    assign up_level   = (up_sum > {1'b0, slbb_pkg::LEVEL_MAX}) ? slbb_pkg::LEVEL_MAX
                                                               : up_sum[6:0];
    assign down_level = (state.dim_level < step) ? 7'd0 : state.dim_level - step;
    assign breathe_level = (dir_sel == slbb_pkg::DIR_UP) ? up_level : down_level;

    always_comb begin
        state_next = state;
        accepted   = 1'b0;
        case (slbb_pkg::func_t'(item.func))
            slbb_pkg::FUNC_TICK: begin
                accepted = 1'b1;
                if (state.mode != slbb_pkg::MODE_BUSY && dim_due) begin
                    state_next.dim_stamp     = item.now_ms;
                    state_next.dim_direction = dir_sel;
                    state_next.dim_level     = breathe_level;
                end
                if ((state.mode == slbb_pkg::MODE_ERROR
                     || state.mode == slbb_pkg::MODE_BUSY) && blink_due) begin
                    state_next.blink_stamp = item.now_ms;
                    state_next.red_on      = ~state.red_on;
                end
                if (state.mode == slbb_pkg::MODE_IDLE) begin
                    state_next.red_on      = 1'b0;
                    state_next.blink_stamp = '0;
                end
                if (state.mode == slbb_pkg::MODE_BUSY) begin
                    state_next.dim_level     = 7'd0;
                    state_next.dim_direction = slbb_pkg::DIR_NONE;
                    state_next.dim_stamp     = '0;
                end
            end
            slbb_pkg::FUNC_SET_MODE: begin
                accepted        = 1'b1;
                state_next      = slbb_pkg::STATE_CLEAR;
                state_next.mode = slbb_pkg::mode_t'(item.new_mode);
            end
            slbb_pkg::FUNC_MANUAL_SET: begin
                if (state.mode == slbb_pkg::MODE_MANUAL) begin
                    accepted          = 1'b1;
                    state_next.red_on = item.manual_on;
                end
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.blue_level   = state_next.dim_level;
        result.red_level    = state_next.red_on ? slbb_pkg::RED_ON_LEVEL : 7'd0;
        result.current_mode = state_next.mode;
        result.accepted     = accepted;
    end

endmodule

// ----- rtl/core/status_led_breathe_blink.sv -----
// Status LED pattern generator with a breathing blue level and a blinking red level.
// Items enter on the s_ channel: a tick carrying the time in milliseconds, a mode
// change, or a manual red setting. Every item yields exactly one result on the m_
// channel with the blue and red levels, the mode in force and an accepted flag.
// An accepted item is held in an input register; its result is computed in one
// pass of short logic against the pattern state and lands in the result register,
// which drives m_valid, once that register is empty or its result is being taken.
// One item is taken per cycle for as long as results are being taken; the state
// update and the result register both advance in the same cycle, so the next item
// always sees the state left by the one before it.
// When m_ready is low the result holds; the input register still takes one more
// item, and s_ready falls only once both registers are full.
// The APB port holds the breathing and blink intervals at byte addresses 0 and 4;
// writes should be made while no item is in flight.
// A synchronous low aresetn empties both registers, sets idle mode with all levels,
// directions and time stamps at zero, and restores the intervals to 10 and 200.
module status_led_breathe_blink (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_func,
    input  logic [31:0]                      s_now_ms,
    input  logic [1:0]                       s_new_mode,
    input  logic                             s_manual_on,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [6:0]                       m_blue_level,
    output logic [6:0]                       m_red_level,
    output logic [1:0]                       m_current_mode,
    output logic                             m_accepted,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slbb_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic               in_valid_reg;
    slbb_pkg::item_t    item_reg;
    logic               out_valid_reg;
    slbb_pkg::result_t  result_reg;
    slbb_pkg::result_t  result_next;
    slbb_pkg::state_t   state_reg;
    slbb_pkg::state_t   state_next;
    logic [15:0]        dim_interval_reg;
    logic [15:0]        blink_interval_reg;
    logic               fire;
    logic               cfg_write;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func      <= s_func;
            item_reg.now_ms    <= slbb_pkg::TIME_BITS'(s_now_ms);
            item_reg.new_mode  <= s_new_mode;
            item_reg.manual_on <= s_manual_on;
        end
    end

    slbb_step u_step (
        .item           (item_reg),
        .state          (state_reg),
        .dim_interval   (dim_interval_reg),
        .blink_interval (blink_interval_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slbb_pkg::STATE_CLEAR;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_blue_level   = result_reg.blue_level;
    assign m_red_level    = result_reg.red_level;
    assign m_current_mode = result_reg.current_mode;
    assign m_accepted     = result_reg.accepted;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_interval_reg   <= slbb_pkg::DIM_RESET;
            blink_interval_reg <= slbb_pkg::BLINK_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                slbb_pkg::REG_DIM_INTERVAL: begin
                    dim_interval_reg <= pwdata[15:0];
                end
                slbb_pkg::REG_BLINK_INTERVAL: begin
                    blink_interval_reg <= pwdata[15:0];
                end
                default: begin
                    dim_interval_reg <= dim_interval_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            slbb_pkg::REG_DIM_INTERVAL: begin
                prdata = {16'd0, dim_interval_reg};
            end
            slbb_pkg::REG_BLINK_INTERVAL: begin
                prdata = {16'd0, blink_interval_reg};
            end
            default: begin
                prdata = 32'd0;
            end
        endcase
    end

endmodule

// ----- rtl/core/slbb_checker.sv -----
module slbb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_blue_level,
    input logic [6:0] m_red_level,
    input logic [1:0] m_current_mode
);

    // A stalled result must stay on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_red_level == 7'd0 || m_red_level == slbb_pkg::RED_ON_LEVEL)
        else $error("red level is neither off nor full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_blue_level <= slbb_pkg::LEVEL_MAX)
        else $error("blue level above full scale");

    // Idle mode never lights red, and busy mode never breathes blue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_current_mode == slbb_pkg::MODE_IDLE |-> m_red_level == 7'd0)
        else $error("red lit in idle mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_current_mode == slbb_pkg::MODE_BUSY |-> m_blue_level == 7'd0)
        else $error("blue lit in busy mode");

endmodule

bind status_led_breathe_blink slbb_checker u_slbb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_blue_level   (m_blue_level),
    .m_red_level    (m_red_level),
    .m_current_mode (m_current_mode)
);
